FILE: rtl/core/opal_pkg.sv
`timescale 1ns / 1ps
// Package for the object pool: sizes, field types, status and operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package opal_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    localparam logic OP_CREATE  = 1'b0;
    localparam logic OP_DESTROY = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EMPTY      = 2'd1,
        STAT_NOT_ACTIVE = 2'd2
    } t_status;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] block_index;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] result_index;
        logic [CNT_W-1:0] active_total;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CR_READ,
        ST_CR_COMMIT,
        ST_SCAN,
        ST_RD_LAST,
        ST_DS_COMMIT,
        ST_REJECT
    } t_state;

    typedef struct packed {
        logic accept;     // request transfer this cycle
        logic cr_read;    // read top of free stack
        logic cr_commit;  // finish a create
        logic scan;       // advance the active-list search
        logic rd_last;    // read last active entry
        logic ds_commit;  // finish a destroy
        logic reject;     // report pool empty or not active
    } t_cmd;

    typedef struct packed {
        logic req_op;
        logic free_empty;
        logic hit;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/opal_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on opal_pkg.
interface opal_req_if;
    logic          valid;
    logic          ready;
    opal_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface opal_rsp_if;
    logic          valid;
    logic          ready;
    opal_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/opal_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the object pool.
// Depends on opal_pkg; drives the datapath through t_cmd and reads t_sts.
module opal_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_op,
    input  opal_pkg::t_sts  i_sts,
    output logic            o_req_ready,
    output opal_pkg::t_cmd  o_cmd
);
    import opal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req_op == OP_DESTROY) ? ST_SCAN : ST_CR_READ;
                end
            end
            ST_CR_READ: begin
                n_state = i_sts.free_empty ? ST_REJECT : ST_CR_COMMIT;
            end
            ST_CR_COMMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_sts.hit) begin
                    n_state = ST_RD_LAST;
                end else if (i_sts.scan_done) begin
                    n_state = ST_REJECT;
                end
            end
            ST_RD_LAST: begin
                n_state = ST_DS_COMMIT;
            end
            ST_DS_COMMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            ST_REJECT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            ST_CR_READ:   o_cmd.cr_read   = !i_sts.free_empty;
            ST_CR_COMMIT: o_cmd.cr_commit = i_sts.out_free;
            ST_SCAN:      o_cmd.scan      = !i_sts.hit;
            ST_RD_LAST:   o_cmd.rd_last   = 1'b1;
            ST_DS_COMMIT: o_cmd.ds_commit = i_sts.out_free;
            ST_REJECT:    o_cmd.reject    = i_sts.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/opal_dp.sv
`timescale 1ns / 1ps
// Datapath for the object pool: free stack and active list memories, counters,
// search pointer and the response register. Depends on opal_pkg.
module opal_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  opal_pkg::t_req  i_req,
    input  opal_pkg::t_cmd  i_cmd,
    input  logic            i_rsp_ready,
    output opal_pkg::t_sts  o_sts,
    output logic            o_rsp_valid,
    output opal_pkg::t_rsp  o_rsp
);
    import opal_pkg::*;

    logic [IDX_W-1:0]     r_free_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] r_free_vld;
    logic [IDX_W-1:0]     r_act_mem  [POOL_SIZE];

    logic [CNT_W-1:0] r_free_cnt;
    logic [CNT_W-1:0] r_act_cnt;
    t_req             r_req;
    logic [CNT_W-1:0] r_scan;
    logic             r_live;
    logic [IDX_W-1:0] r_prev;
    logic [IDX_W-1:0] r_act_q;
    logic [IDX_W-1:0] r_fs_q;
    logic             r_fs_vld;
    logic [IDX_W-1:0] r_fs_addr;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [CNT_W-1:0] w_free_dec;
    logic [CNT_W-1:0] w_act_dec;
    logic [IDX_W-1:0] w_pop_idx;
    logic             w_scan_issue;
    logic             w_push;
    logic             w_act_we;
    logic [IDX_W-1:0] w_act_waddr;
    logic [IDX_W-1:0] w_act_wdata;
    logic             w_act_re;
    logic [IDX_W-1:0] w_act_raddr;
    logic             w_out_free;

    assign w_free_dec   = r_free_cnt - CNT_W'(1);
    assign w_act_dec    = r_act_cnt - CNT_W'(1);
    // Entries never written since reset are taken to hold their own index.
    assign w_pop_idx    = r_fs_vld ? r_fs_q : r_fs_addr;
    assign w_scan_issue = i_cmd.scan && (r_scan < r_act_cnt);
    assign w_push       = i_cmd.ds_commit && (r_free_cnt < CNT_W'(POOL_SIZE));

    // On a destroy the last active entry is copied into the freed slot.
    assign w_act_we    = i_cmd.cr_commit || i_cmd.ds_commit;
    assign w_act_waddr = i_cmd.cr_commit ? r_act_cnt[IDX_W-1:0] : r_prev;
    assign w_act_wdata = i_cmd.cr_commit ? w_pop_idx : r_act_q;
    assign w_act_re    = w_scan_issue || i_cmd.rd_last;
    assign w_act_raddr = i_cmd.rd_last ? w_act_dec[IDX_W-1:0] : r_scan[IDX_W-1:0];

    assign w_out_free  = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_free_mem[r_free_cnt[IDX_W-1:0]] <= r_req.block_index;
        if (i_cmd.cr_read) r_fs_q <= r_free_mem[w_free_dec[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_vld <= '0;
        end else if (w_push) begin
            r_free_vld[r_free_cnt[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cr_read) begin
            r_fs_vld  <= r_free_vld[w_free_dec[IDX_W-1:0]];
            r_fs_addr <= w_free_dec[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_act_we) r_act_mem[w_act_waddr] <= w_act_wdata;
        if (w_act_re) r_act_q <= r_act_mem[w_act_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= CNT_W'(POOL_SIZE);
            r_act_cnt  <= '0;
        end else if (i_cmd.cr_commit) begin
            r_free_cnt <= w_free_dec;
            r_act_cnt  <= r_act_cnt + CNT_W'(1);
        end else if (i_cmd.ds_commit) begin
            r_act_cnt <= w_act_dec;
            if (w_push) r_free_cnt <= r_free_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_req <= i_req;
        if (w_scan_issue) r_prev <= r_scan[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
            r_live <= 1'b0;
        end else if (i_cmd.accept) begin
            r_scan <= '0;
            r_live <= 1'b0;
        end else if (i_cmd.scan) begin
            r_live <= w_scan_issue;
            if (w_scan_issue) r_scan <= r_scan + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.cr_commit || i_cmd.ds_commit || i_cmd.reject) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cr_commit) begin
            r_out.status       <= STAT_OK;
            r_out.result_index <= w_pop_idx;
            r_out.active_total <= r_act_cnt + CNT_W'(1);
        end else if (i_cmd.ds_commit) begin
            r_out.status       <= STAT_OK;
            r_out.result_index <= r_req.block_index;
            r_out.active_total <= w_act_dec;
        end else if (i_cmd.reject) begin
            r_out.status       <= (r_req.operation == OP_DESTROY) ? STAT_NOT_ACTIVE
                                                                  : STAT_EMPTY;
            r_out.result_index <= '0;
            r_out.active_total <= r_act_cnt;
        end
    end

    assign o_sts.req_op     = r_req.operation;
    assign o_sts.free_empty = (r_free_cnt == '0);
    assign o_sts.hit        = r_live && (r_act_q == r_req.block_index);
    assign o_sts.scan_done  = !r_live && (r_scan >= r_act_cnt);
    assign o_sts.out_free   = w_out_free;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

FILE: rtl/core/object_pool_with_active_list.sv
`timescale 1ns / 1ps
// Object pool with active list: top level joining controller and datapath.
// Depends on opal_pkg, opal_if, opal_ctrl and opal_dp.

// One request at a time, one response per request. A create passes through
// request transfer, free-stack read and commit. A destroy reads the active
// list one entry per cycle through its single read port until it finds the
// index, then reads the last active entry and commits. A destroy of an index
// that is not active reads every active entry before it is rejected, or is
// rejected without a read on an empty list. The response waits in an output
// register, and the block only stalls at the end of its next request if that
// register has not yet been taken. No clearing pass follows reset.
module object_pool_with_active_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    opal_req_if.sink    i_req,
    opal_rsp_if.source  o_rsp
);
    import opal_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    opal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.data.operation),
        .i_sts       (w_sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd)
    );

    opal_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req.data),
        .i_cmd       (w_cmd),
        .i_rsp_ready (o_rsp.ready),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp       (o_rsp.data)
    );

    // The controller issues at most one datapath command per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command in a cycle");

    // Once a request is taken the block is not ready again in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while previous one in progress");

    // Responses carry a legal status and a count within the pool.
    a_rsp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.data.active_total <= CNT_W'(POOL_SIZE))
                        && (o_rsp.data.status == STAT_OK
                            || o_rsp.data.status == STAT_EMPTY
                            || o_rsp.data.status == STAT_NOT_ACTIVE))
        else $error("response out of range");

endmodule
